[rtl/core/aicp_pkg.sv]
// Shared types and constants of the animated image container parser.
// Used by aicp_front, aicp_queue and animated_image_container_parser_top.
package aicp_pkg;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_BODY
  } aicp_phase_t;

  localparam logic [4:0] K_BLOCK      = 5'd0;
  localparam logic [4:0] K_FMAGIC     = 5'd1;
  localparam logic [4:0] K_HDR_SIZE   = 5'd2;
  localparam logic [4:0] K_ANIM_CNT   = 5'd3;
  localparam logic [4:0] K_YEAR       = 5'd4;
  localparam logic [4:0] K_MONTH      = 5'd5;
  localparam logic [4:0] K_DAY        = 5'd6;
  localparam logic [4:0] K_HOUR       = 5'd7;
  localparam logic [4:0] K_MINUTE     = 5'd8;
  localparam logic [4:0] K_CREAT_LEN  = 5'd9;
  localparam logic [4:0] K_CREAT_BYTE = 5'd10;
  localparam logic [4:0] K_DURATION   = 5'd11;
  localparam logic [4:0] K_IMAGIC     = 5'd12;
  localparam logic [4:0] K_IHDR_SIZE  = 5'd13;
  localparam logic [4:0] K_CONT_SIZE  = 5'd14;
  localparam logic [4:0] K_WIDTH      = 5'd15;
  localparam logic [4:0] K_HEIGHT     = 5'd16;
  localparam logic [4:0] K_CAPTION    = 5'd17;
  localparam logic [4:0] K_TAG        = 5'd18;
  localparam logic [4:0] K_PIXEL      = 5'd19;

  localparam logic [7:0] BT_HEADER  = 8'd1;
  localparam logic [7:0] BT_CREDITS = 8'd2;
  localparam logic [7:0] BT_ANIM    = 8'd3;

  localparam logic [31:0] MAGIC_FILE  = 32'h4646_4143;
  localparam logic [31:0] MAGIC_IMAGE = 32'h4646_4943;
  localparam logic [7:0]  CHAR_NL     = 8'h0A;
  localparam logic [7:0]  CHAR_NUL    = 8'h00;
  localparam logic [7:0]  CHAR_HASH   = 8'h23;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [7:0]  btype;
    logic        mism;
    logic        done;
  } aicp_evt_t;

endpackage

[rtl/core/aicp_front.sv]
// Front end: tracks block framing and turns block lengths and body bytes into field events.
// Depends on aicp_pkg.
module aicp_front
  import aicp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output logic        evt_valid,
  output aicp_evt_t   evt
);

  typedef struct packed {
    logic       hit;
    logic [2:0] pos;
    logic       fin;
    logic [4:0] kind;
  } aicp_fld_t;

  aicp_phase_t phase_r, phase_nxt;
  logic [63:0] off_r, off_nxt;
  logic [63:0] blen_r, blen_nxt;
  logic [7:0]  btype_r, btype_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] ihs_r, ihs_nxt;
  logic [63:0] ics_r, ics_nxt;
  logic [63:0] clen_r, clen_nxt;
  logic        capdone_r, capdone_nxt;

  function automatic aicp_fld_t mk(input logic [5:0] o, input logic [5:0] s,
                                   input logic [3:0] n, input logic [4:0] k);
    aicp_fld_t f;
    logic [5:0] p;
    p = o - s;
    f.hit  = 1'b1;
    f.pos  = p[2:0];
    f.fin  = (p == {2'b00, n - 4'd1});
    f.kind = k;
    return f;
  endfunction

  function automatic aicp_fld_t lookup(input logic [7:0] bt, input logic [5:0] o);
    aicp_fld_t f;
    f = '0;
    case (bt)
      BT_HEADER: begin
        if (o inside {[0:3]})        f = mk(o, 6'd0, 4'd4, K_FMAGIC);
        else if (o inside {[4:11]})  f = mk(o, 6'd4, 4'd8, K_HDR_SIZE);
        else if (o inside {[12:19]}) f = mk(o, 6'd12, 4'd8, K_ANIM_CNT);
      end
      BT_CREDITS: begin
        if (o inside {[0:1]})        f = mk(o, 6'd0, 4'd2, K_YEAR);
        else if (o == 6'd2)          f = mk(o, 6'd2, 4'd1, K_MONTH);
        else if (o == 6'd3)          f = mk(o, 6'd3, 4'd1, K_DAY);
        else if (o == 6'd4)          f = mk(o, 6'd4, 4'd1, K_HOUR);
        else if (o == 6'd5)          f = mk(o, 6'd5, 4'd1, K_MINUTE);
        else if (o inside {[6:13]})  f = mk(o, 6'd6, 4'd8, K_CREAT_LEN);
      end
      BT_ANIM: begin
        if (o inside {[0:7]})        f = mk(o, 6'd0, 4'd8, K_DURATION);
        else if (o inside {[8:11]})  f = mk(o, 6'd8, 4'd4, K_IMAGIC);
        else if (o inside {[12:19]}) f = mk(o, 6'd12, 4'd8, K_IHDR_SIZE);
        else if (o inside {[20:27]}) f = mk(o, 6'd20, 4'd8, K_CONT_SIZE);
        else if (o inside {[28:35]}) f = mk(o, 6'd28, 4'd8, K_WIDTH);
        else if (o inside {[36:43]}) f = mk(o, 6'd36, 4'd8, K_HEIGHT);
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  aicp_fld_t   fld;
  logic        low_off;
  logic        last;
  logic [63:0] rel;
  logic [63:0] cro;
  logic [63:0] shb;
  logic [63:0] fval;

  always_comb begin
    low_off = (off_r[63:6] == '0) && (off_r[5:0] < 6'd44);
    fld     = low_off ? lookup(btype_r, off_r[5:0]) : '0;
    last    = ((off_r + 64'd1) == blen_r);
    rel     = off_r - 64'd8;
    cro     = off_r - 64'd14;
    shb     = {56'b0, data_byte} << {fld.pos, 3'b000};
    fval    = ((fld.pos == 3'd0) ? 64'd0 : acc_r) | shb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= '0;
      blen_r    <= '0;
      btype_r   <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      ihs_r     <= '0;
      ics_r     <= '0;
      clen_r    <= '0;
      capdone_r <= 1'b0;
    end else begin
      off_r     <= off_nxt;
      blen_r    <= blen_nxt;
      btype_r   <= btype_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      ihs_r     <= ihs_nxt;
      ics_r     <= ics_nxt;
      clen_r    <= clen_nxt;
      capdone_r <= capdone_nxt;
    end
  end

  always_comb begin
    logic [63:0] lacc;
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    blen_nxt    = blen_r;
    btype_nxt   = btype_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    ihs_nxt     = ihs_r;
    ics_nxt     = ics_r;
    clen_nxt    = clen_r;
    capdone_nxt = capdone_r;
    evt_valid   = 1'b0;
    evt.kind    = K_BLOCK;
    evt.value   = '0;
    evt.btype   = btype_r;
    evt.mism    = 1'b0;
    evt.done    = 1'b0;
    lacc = acc_r | ({56'b0, data_byte} << {cnt_r[2:0], 3'b000});
    case (phase_r)
      PH_ID: begin
        if (take) begin
          btype_nxt   = data_byte;
          cnt_nxt     = '0;
          acc_nxt     = '0;
          capdone_nxt = 1'b0;
          phase_nxt   = PH_LEN;
        end
      end
      PH_LEN: begin
        if (take) begin
          acc_nxt = lacc;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd7) begin
            blen_nxt  = lacc;
            off_nxt   = '0;
            cnt_nxt   = '0;
            evt_valid = 1'b1;
            evt.value = lacc;
            evt.done  = (lacc == '0);
            phase_nxt = (lacc == '0) ? PH_ID : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (take) begin
          if (fld.hit) begin
            acc_nxt = fval;
            if (fld.fin) begin
              evt_valid = 1'b1;
              evt.kind  = fld.kind;
              evt.value = fval;
              if (fld.kind == K_FMAGIC)    evt.mism = (fval[31:0] != MAGIC_FILE);
              if (fld.kind == K_IMAGIC)    evt.mism = (fval[31:0] != MAGIC_IMAGE);
              if (fld.kind == K_CREAT_LEN) clen_nxt = fval;
              if (fld.kind == K_IHDR_SIZE) ihs_nxt  = fval;
              if (fld.kind == K_CONT_SIZE) ics_nxt  = fval;
            end
          end
          if (btype_r == BT_CREDITS && off_r >= 64'd14 && cro < clen_r) begin
            evt_valid = 1'b1;
            evt.kind  = K_CREAT_BYTE;
            evt.value = {56'b0, data_byte};
          end
          if (btype_r == BT_ANIM && !low_off) begin
            if (rel < ihs_r) begin
              evt_valid = 1'b1;
              if (!capdone_r) begin
                evt.kind  = K_CAPTION;
                evt.value = {56'b0, data_byte};
                if (data_byte == CHAR_NL) capdone_nxt = 1'b1;
              end else begin
                evt.kind  = K_TAG;
                evt.value = {56'b0, (data_byte == CHAR_NUL) ? CHAR_HASH : data_byte};
              end
            end else if ((rel - ihs_r) < ics_r) begin
              evt_valid = 1'b1;
              evt.kind  = K_PIXEL;
              evt.value = {56'b0, data_byte};
            end
          end
          off_nxt  = off_r + 64'd1;
          evt.done = last;
          if (last) begin
            phase_nxt = PH_ID;
            if (!evt_valid) begin
              evt_valid = 1'b1;
              evt.kind  = K_BLOCK;
              evt.value = blen_r;
              evt.mism  = 1'b0;
            end
          end
        end
      end
      default: phase_nxt = PH_ID;
    endcase
  end

endmodule

[rtl/core/aicp_queue.sv]
// Short event queue between the parser front and the result port.
// Depends on aicp_pkg.
module aicp_queue
  import aicp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  aicp_evt_t wdata,
  input  logic      rd,
  output aicp_evt_t rdata,
  output logic      full,
  output logic      empty
);

  aicp_evt_t     mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[QAW-1:0]) else $error("queue pointers and count disagree");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop beat did not drain queue");

endmodule

[rtl/core/animated_image_container_parser_top.sv]
// Top level of the animated image container parser.
// Depends on aicp_pkg, aicp_front and aicp_queue.
//
// The parser takes one container byte per cycle while the four-entry event queue has room
// and emits at most one field event per byte. A byte is taken in the same cycle it is pushed;
// the front parser state is updated in that cycle, so the sustained rate is one byte per clock
// while events are popped. An event is queued as its byte is accepted, reaches the out_ ports
// once earlier events are popped and stays until popped. full rises only when four events wait unpopped.
module animated_image_container_parser_top
  import aicp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_event_kind,
  output logic [63:0] out_field_value,
  output logic [7:0]  out_block_type,
  output logic        out_magic_mismatch,
  output logic        out_block_done
);

  logic      take;
  logic      evt_valid;
  aicp_evt_t evt;
  aicp_evt_t head;

  assign take = in_push && !full;

  aicp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  aicp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (evt_valid),
    .wdata (evt),
    .rd    (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  assign out_event_kind     = head.kind;
  assign out_field_value    = head.value;
  assign out_block_type     = head.btype;
  assign out_magic_mismatch = head.mism;
  assign out_block_done     = head.done;

endmodule
